// ----- rtl/core/hmq_pkg.sv -----
// Shared types, constants and helpers for the min-heap priority queue.
package hmq_pkg;

	localparam int CAPACITY  = 16;
	localparam int KEY_WIDTH = 32;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	typedef logic signed [KEY_WIDTH-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic REQ_INSERT  = 1'b0;
	localparam logic REQ_EXTRACT = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef struct packed {
		logic               req_type;
		logic signed [31:0] key;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result_key;
		status_t            status;
		logic [4:0]         occupancy;
	} rsp_t;

	// Per-cycle command broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic ext;
		key_t key;
	} cell_ctl_t;

	// Largest positive key.
	localparam key_t KEY_MAXV = {1'b0, {(KEY_WIDTH-1){1'b1}}};

	// Take the low KEY_WIDTH bits of a request key, as a signed key.
	function automatic key_t to_key(logic signed [31:0] k);
		logic signed [63:0] w;
		w = 64'(k);
		return w[KEY_WIDTH-1:0];
	endfunction

	// Sign-extend or truncate a key to the 32-bit result field.
	function automatic logic signed [31:0] to_out(key_t k);
		logic signed [63:0] w;
		w = 64'(k);
		return w[31:0];
	endfunction

endpackage

// ----- rtl/core/hmq_cell.sv -----
// One slot of the sorted key chain: compares against the request key and shifts.
module hmq_cell (
	input  logic               clk,
	input  hmq_pkg::cell_ctl_t ctl,
	input  logic               occ,
	input  hmq_pkg::key_t      left_key,
	input  logic               left_gt,
	input  hmq_pkg::key_t      right_key,
	output hmq_pkg::key_t      key,
	output logic               gt
);

	hmq_pkg::key_t key_q;

	// An empty slot behaves as plus infinity.
	assign gt  = !occ || (key_q > ctl.key);
	assign key = key_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (gt) begin
				key_q <= left_gt ? left_key : ctl.key;
			end
		end else if (ctl.ext) begin
			key_q <= right_key;
		end
	end

endmodule

// ----- rtl/core/binary_min_heap_queue.sv -----
// Top level of the bounded min-priority queue of signed keys.
// Takes one request per clock cycle: busy stays low, and start is accepted at
// every rising edge where it is high. The result of a request appears on rsp
// for exactly one cycle, with done high, in the cycle after it was accepted;
// the receiver must take it then. Keys live in a chain of CAPACITY cells kept
// in ascending order; an insert compares the new key in every cell at once and
// shifts the larger keys one cell up, an extract shifts the chain one cell down
// and returns the head. A full insert reports overflow, an empty extract
// reports empty with the largest positive key, and each result carries the
// occupancy after the request.
module binary_min_heap_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  hmq_pkg::req_t req,
	output logic          done,
	output hmq_pkg::rsp_t rsp
);

	localparam int N = hmq_pkg::CAPACITY;

	hmq_pkg::cnt_t      count_q;
	logic               done_q;
	hmq_pkg::rsp_t      rsp_q;
	hmq_pkg::cell_ctl_t ctl;
	hmq_pkg::key_t      cell_key [N];
	logic               cell_gt  [N];
	logic               accept;
	logic               full;
	logic               empty;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (count_q == hmq_pkg::CNT_W'(N));
	assign empty  = (count_q == '0);

	always_comb begin
		ctl.key = hmq_pkg::to_key(req.key);
		ctl.ins = accept && (req.req_type == hmq_pkg::REQ_INSERT) && !full;
		ctl.ext = accept && (req.req_type == hmq_pkg::REQ_EXTRACT) && !empty;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		hmq_pkg::key_t lk;
		logic          lg;
		hmq_pkg::key_t rk;
		logic          occ;

		assign occ = (count_q > hmq_pkg::CNT_W'(i));
		if (i == 0) begin : g_first
			assign lk = ctl.key;
			assign lg = 1'b0;
		end else begin : g_mid
			assign lk = cell_key[i-1];
			assign lg = cell_gt[i-1];
		end
		if (i == N - 1) begin : g_last
			assign rk = cell_key[i];
		end else begin : g_inner
			assign rk = cell_key[i+1];
		end

		hmq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ),
			.left_key  (lk),
			.left_gt   (lg),
			.right_key (rk),
			.key       (cell_key[i]),
			.gt        (cell_gt[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctl.ins) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.ext) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.req_type == hmq_pkg::REQ_INSERT) begin
				rsp_q.result_key <= '0;
				if (full) begin
					rsp_q.status    <= hmq_pkg::ST_OVERFLOW;
					rsp_q.occupancy <= 5'(count_q);
				end else begin
					rsp_q.status    <= hmq_pkg::ST_OK;
					rsp_q.occupancy <= 5'(count_q + 1'b1);
				end
			end else begin
				if (empty) begin
					rsp_q.result_key <= hmq_pkg::to_out(hmq_pkg::KEY_MAXV);
					rsp_q.status     <= hmq_pkg::ST_EMPTY;
					rsp_q.occupancy  <= 5'(count_q);
				end else begin
					rsp_q.result_key <= hmq_pkg::to_out(cell_key[0]);
					rsp_q.status     <= hmq_pkg::ST_OK;
					rsp_q.occupancy  <= 5'(count_q - 1'b1);
				end
			end
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
